/* rtl/tesc_pkg.sv */
// Shared types and constants for the terminal escape decoder.
// Holds the command codes, parse phase codes, cell geometry and the
// queued command record used by the decoder and the top level.
`default_nettype none

package tesc_pkg;

  // Character cell geometry in pixels
  localparam int CHAR_WIDTH  = 9;
  localparam int CHAR_HEIGHT = 14;
  localparam int X_INSET     = 5;
  localparam int Y_INSET     = 3;

  // Signed cell coordinate, wide enough for derived rectangle corners
  localparam int CELL_W = 10;
  typedef logic signed [CELL_W-1:0] cell_t;

  // Display command codes
  typedef enum logic [2:0] {
    CMD_GLYPH = 3'd0,
    CMD_COPY  = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_BELL  = 3'd3,
    CMD_BOOT  = 3'd4
  } cmd_t;

  // Escape parser phases; unused codes behave as normal text
  localparam logic [2:0] PH_NORMAL = 3'd0;
  localparam logic [2:0] PH_ESC    = 3'd1;
  localparam logic [2:0] PH_YCOL   = 3'd2;
  localparam logic [2:0] PH_YROW   = 3'd3;
  localparam logic [2:0] PH_EDIT   = 3'd4;

  // Cursor and parser state
  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] edit;
    logic [7:0] pcol;
    logic [6:0] col;
    logic [6:0] row;
  } st_t;

  // One display command in cell coordinates, converted to pixels on exit
  typedef struct packed {
    cmd_t       cmd;
    cell_t      left;
    cell_t      top;
    cell_t      right;
    cell_t      bottom;
    cell_t      dest_x;
    cell_t      dest_y;
    logic [6:0] glyph;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/tesc_decode.sv */
// Single-pass decode of one received byte against the cursor and parser state.
// Produces the next state and up to four commands in cell coordinates.
// Depends on tesc_pkg.
`default_nettype none

module tesc_decode (
  input  tesc_pkg::st_t          st,
  input  logic [6:0]             last_column,
  input  logic [6:0]             last_row,
  input  logic [7:0]             rx_byte,
  output tesc_pkg::st_t          st_next,
  output tesc_pkg::res_t [3:0]   res,
  output logic [2:0]             res_cnt
);

  // Control bytes
  localparam logic [6:0] CH_BEL = 7'h07;
  localparam logic [6:0] CH_BS  = 7'h08;
  localparam logic [6:0] CH_TAB = 7'h09;
  localparam logic [6:0] CH_LF  = 7'h0A;
  localparam logic [6:0] CH_VT  = 7'h0B;
  localparam logic [6:0] CH_FF  = 7'h0C;
  localparam logic [6:0] CH_CR  = 7'h0D;
  localparam logic [6:0] CH_DLE = 7'h10;
  localparam logic [6:0] CH_ESC = 7'h1B;

  // Escape letters
  localparam logic [6:0] CH_UP        = 7'h41;
  localparam logic [6:0] CH_DOWN      = 7'h42;
  localparam logic [6:0] CH_RIGHT     = 7'h43;
  localparam logic [6:0] CH_LEFT      = 7'h44;
  localparam logic [6:0] CH_DEL_LINES = 7'h45;
  localparam logic [6:0] CH_INS_LINES = 7'h46;
  localparam logic [6:0] CH_ERASE_EOL = 7'h4B;
  localparam logic [6:0] CH_PLACE     = 7'h59;
  localparam logic [6:0] CH_DEL_CHARS = 7'h65;
  localparam logic [6:0] CH_INS_CHARS = 7'h66;

  // Pending edit kinds
  localparam logic [1:0] ED_DEL_LINES = 2'd0;
  localparam logic [1:0] ED_DEL_CHARS = 2'd1;
  localparam logic [1:0] ED_INS_LINES = 2'd2;
  localparam logic [1:0] ED_INS_CHARS = 2'd3;

  localparam logic [7:0] PARAM_BIAS = 8'd32;

  typedef struct packed {
    logic           hit;
    tesc_pkg::res_t cp;
    tesc_pkg::res_t cl;
  } mv_t;

  function automatic tesc_pkg::res_t mk(tesc_pkg::cmd_t cmd,
                                        tesc_pkg::cell_t l, tesc_pkg::cell_t t,
                                        tesc_pkg::cell_t r, tesc_pkg::cell_t b,
                                        tesc_pkg::cell_t dx, tesc_pkg::cell_t dy,
                                        logic [6:0] g);
    tesc_pkg::res_t e;
    e.cmd    = cmd;
    e.left   = l;
    e.top    = t;
    e.right  = r;
    e.bottom = b;
    e.dest_x = dx;
    e.dest_y = dy;
    e.glyph  = g;
    e.last   = 1'b0;
    return e;
  endfunction

  function automatic tesc_pkg::cell_t clamp(tesc_pkg::cell_t v, tesc_pkg::cell_t hi);
    tesc_pkg::cell_t r;
    r = v;
    if (v < 0) begin
      r = '0;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // Copy a block of cells and clear the strip it leaves behind
  function automatic mv_t move_block(tesc_pkg::cell_t ox_i, tesc_pkg::cell_t oy_i,
                                     tesc_pkg::cell_t cx_i, tesc_pkg::cell_t cy_i,
                                     tesc_pkg::cell_t px_i, tesc_pkg::cell_t py_i,
                                     tesc_pkg::cell_t cm1, tesc_pkg::cell_t rm1);
    mv_t m;
    tesc_pkg::cell_t ox, oy, cx, cy, px, py;
    ox = clamp(ox_i, cm1);
    oy = clamp(oy_i, rm1);
    cx = clamp(cx_i, cm1);
    cy = clamp(cy_i, rm1);
    px = clamp(px_i, cm1);
    py = clamp(py_i, rm1);
    m.hit = !((px == ox) && (py == oy));
    m.cp  = mk(tesc_pkg::CMD_COPY, ox, oy, cx, cy, px, py, 7'd0);
    if (px == ox) begin
      if (py < oy) begin
        m.cl = mk(tesc_pkg::CMD_CLEAR, px, cy - oy + py, cx, cy, '0, '0, 7'd0);
      end else begin
        m.cl = mk(tesc_pkg::CMD_CLEAR, ox, oy, cx, py, '0, '0, 7'd0);
      end
    end else begin
      if (px < ox) begin
        m.cl = mk(tesc_pkg::CMD_CLEAR, cx - ox + px, py, cx, cy, '0, '0, 7'd0);
      end else begin
        m.cl = mk(tesc_pkg::CMD_CLEAR, ox, oy, px, cy, '0, '0, 7'd0);
      end
    end
    return m;
  endfunction

  always_comb begin
    logic [6:0]      c;
    tesc_pkg::cell_t cmax, rmax, cm1, rm1, n, col, row;
    tesc_pkg::res_t  p0, p1, scr0, scr1;
    logic [1:0]      pn;
    logic            wn, lf, done;
    mv_t             mv;

    c    = rx_byte[6:0];
    cmax = $signed({3'b000, last_column});
    rmax = $signed({3'b000, last_row});
    cm1  = cmax + 10'sd1;
    rm1  = rmax + 10'sd1;
    n    = $signed({3'b000, c}) - 10'sd32;
    col  = $signed({3'b000, st.col});
    row  = $signed({3'b000, st.row});

    // Scroll by one line: shift rows up and blank the bottom row
    scr0 = mk(tesc_pkg::CMD_COPY, '0, 10'sd1, cm1, rm1, '0, '0, 7'd0);
    scr1 = mk(tesc_pkg::CMD_CLEAR, '0, rmax, cm1, rm1, '0, '0, 7'd0);

    st_next = st;
    done    = 1'b1;
    lf      = 1'b0;
    wn      = 1'b0;
    pn      = 2'd0;
    p0      = '0;
    p1      = '0;
    mv      = '0;

    // Step the parser
    unique case (st.phase)
      tesc_pkg::PH_ESC: begin
        st_next.phase = tesc_pkg::PH_NORMAL;
        unique case (c)
          CH_PLACE:     st_next.phase = tesc_pkg::PH_YCOL;
          CH_UP:        row = row - 10'sd1;
          CH_DOWN:      lf = 1'b1;
          CH_RIGHT:     col = col + 10'sd1;
          CH_LEFT:      col = col - 10'sd1;
          CH_DEL_LINES: begin
            st_next.edit  = ED_DEL_LINES;
            st_next.phase = tesc_pkg::PH_EDIT;
          end
          CH_DEL_CHARS: begin
            st_next.edit  = ED_DEL_CHARS;
            st_next.phase = tesc_pkg::PH_EDIT;
          end
          CH_INS_LINES: begin
            st_next.edit  = ED_INS_LINES;
            st_next.phase = tesc_pkg::PH_EDIT;
          end
          CH_INS_CHARS: begin
            st_next.edit  = ED_INS_CHARS;
            st_next.phase = tesc_pkg::PH_EDIT;
          end
          CH_ERASE_EOL: begin
            p0 = mk(tesc_pkg::CMD_CLEAR, col, row, cm1, row + 10'sd1, '0, '0, 7'd0);
            pn = 2'd1;
          end
          default: ;
        endcase
        done = (st_next.phase == tesc_pkg::PH_NORMAL);
      end
      tesc_pkg::PH_YCOL: begin
        st_next.pcol  = {1'b0, c} - PARAM_BIAS;
        st_next.phase = tesc_pkg::PH_YROW;
        done          = 1'b0;
      end
      tesc_pkg::PH_YROW: begin
        col = clamp($signed({{2{st.pcol[7]}}, st.pcol}), cmax);
        row = clamp(n, rmax);
        st_next.phase = tesc_pkg::PH_NORMAL;
      end
      tesc_pkg::PH_EDIT: begin
        st_next.phase = tesc_pkg::PH_NORMAL;
        unique case (st.edit)
          ED_DEL_LINES: mv = move_block('0, row + n, cm1, rm1, '0, row, cm1, rm1);
          ED_DEL_CHARS: mv = move_block(col + n, row, cm1, row + 10'sd1, col, row, cm1, rm1);
          ED_INS_LINES: mv = move_block('0, row, cm1, rm1 - n, '0, row + n, cm1, rm1);
          ED_INS_CHARS: mv = move_block(col, row, cm1 - n, row + 10'sd1, col + n, row, cm1, rm1);
        endcase
        if (mv.hit) begin
          p0 = mv.cp;
          p1 = mv.cl;
          pn = 2'd2;
        end
      end
      default: begin
        st_next.phase = tesc_pkg::PH_NORMAL;
        unique case (c)
          CH_DLE: begin
            p0   = mk(tesc_pkg::CMD_BOOT, '0, '0, '0, '0, '0, '0, 7'd0);
            pn   = 2'd1;
            done = 1'b0;
          end
          CH_BEL: begin
            p0 = mk(tesc_pkg::CMD_BELL, '0, '0, '0, '0, '0, '0, 7'd0);
            pn = 2'd1;
          end
          CH_VT:  row = row - 10'sd1;
          CH_TAB: col = (col | 10'sd7) + 10'sd1;
          CH_ESC: begin
            st_next.phase = tesc_pkg::PH_ESC;
            done          = 1'b0;
          end
          CH_BS:  col = col - 10'sd1;
          CH_LF:  lf = 1'b1;
          CH_CR:  col = '0;
          CH_FF: begin
            p0  = mk(tesc_pkg::CMD_CLEAR, '0, '0, cm1, rm1, '0, '0, 7'd0);
            pn  = 2'd1;
            col = '0;
            row = '0;
          end
          default: begin
            p0  = mk(tesc_pkg::CMD_GLYPH, col, row, '0, '0, '0, '0, c);
            pn  = 2'd1;
            col = col + 10'sd1;
          end
        endcase
      end
    endcase

    // Explicit line feed: scroll at the bottom row
    if (lf) begin
      if (row >= rmax) begin
        p0  = scr0;
        p1  = scr1;
        pn  = 2'd2;
        row = rmax;
      end else begin
        row = row + 10'sd1;
      end
    end

    // Wrap past the right edge, then clip the cursor
    if (done) begin
      if (col > cmax) begin
        if (row >= rmax) begin
          wn  = 1'b1;
          row = rmax;
        end else begin
          row = row + 10'sd1;
        end
        col = '0;
      end
      col = clamp(col, cm1);
      row = clamp(row, rm1);
    end
    st_next.col = col[6:0];
    st_next.row = row[6:0];

    // Order the commands: primary ones first, then the wrap scroll
    res = '0;
    unique case (pn)
      2'd0: begin
        if (wn) begin
          res[0] = scr0;
          res[1] = scr1;
        end
      end
      2'd1: begin
        res[0] = p0;
        if (wn) begin
          res[1] = scr0;
          res[2] = scr1;
        end
      end
      default: begin
        res[0] = p0;
        res[1] = p1;
        if (wn) begin
          res[2] = scr0;
          res[3] = scr1;
        end
      end
    endcase
    res_cnt = {1'b0, pn} + {1'b0, wn, 1'b0};
    if (res_cnt != 3'd0) begin
      res[2'(res_cnt - 3'd1)].last = 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/terminal_escape_decoder.sv */
// Flow: a byte accepted into the input register is decoded into the command
// queue once the queue is empty or its last entry leaves. Throughput: one byte
// per cycle while each byte yields at most one command and the output is not
// stalled; a byte yielding k commands (up to four) holds the input while the
// queue drains one entry per cycle through the output register, unless stalled.
// Reset clears cursor, parser and queue, and loads last_column 86, last_row 71.
`default_nettype none

module terminal_escape_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  command,
  output logic [10:0] left_px,
  output logic [10:0] top_px,
  output logic [10:0] right_px,
  output logic [10:0] bottom_px,
  output logic [10:0] dest_x_px,
  output logic [10:0] dest_y_px,
  output logic [6:0]  glyph_code,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam logic [1:0] REG_LAST_COLUMN = 2'd0;
  localparam logic [1:0] REG_LAST_ROW    = 2'd1;
  localparam logic [6:0] LAST_COLUMN_RST = 7'd86;
  localparam logic [6:0] LAST_ROW_RST    = 7'd71;

  function automatic logic [10:0] xpix(tesc_pkg::cell_t v);
    logic [13:0] p;
    p = 14'(v[8:0]) * 14'(tesc_pkg::CHAR_WIDTH) + 14'(tesc_pkg::X_INSET);
    if (v[tesc_pkg::CELL_W-1]) begin
      p = 14'(tesc_pkg::X_INSET);
    end
    return p[10:0];
  endfunction

  function automatic logic [10:0] ypix(tesc_pkg::cell_t v);
    logic [13:0] p;
    p = 14'(v[8:0]) * 14'(tesc_pkg::CHAR_HEIGHT) + 14'(tesc_pkg::Y_INSET);
    if (v[tesc_pkg::CELL_W-1]) begin
      p = 14'(tesc_pkg::Y_INSET);
    end
    return p[10:0];
  endfunction

  logic [6:0]           last_column;
  logic [6:0]           last_row;
  tesc_pkg::st_t        st;
  tesc_pkg::st_t        st_next;
  logic                 in_full;
  logic [7:0]           in_byte;
  tesc_pkg::res_t       bufr [4];
  logic [2:0]           buf_cnt;
  tesc_pkg::res_t [3:0] dec_res;
  logic [2:0]           dec_cnt;
  logic                 pop;
  logic                 fire;
  tesc_pkg::res_t       head;
  logic                 use_pos;
  logic                 use_rect;
  logic                 use_dest;

  assign cfg_ready = 1'b1;

  // Handshake: pop the queue head when the output is free, decode when the
  // queue is empty or its last entry leaves this cycle
  assign pop      = (buf_cnt != 3'd0) && (!out_valid || !out_stall);
  assign fire     = in_full && ((buf_cnt == 3'd0) || ((buf_cnt == 3'd1) && pop));
  assign in_stall = in_full && !fire;

  tesc_decode u_decode (
    .st          (st),
    .last_column (last_column),
    .last_row    (last_row),
    .rx_byte     (in_byte),
    .st_next     (st_next),
    .res         (dec_res),
    .res_cnt     (dec_cnt)
  );

  // Control state: config, parser state, fill flags
  always_ff @(posedge clk) begin
    if (rst) begin
      last_column <= LAST_COLUMN_RST;
      last_row    <= LAST_ROW_RST;
      st          <= '0;
      in_full     <= 1'b0;
      buf_cnt     <= 3'd0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_LAST_COLUMN: last_column <= cfg_data;
          REG_LAST_ROW:    last_row    <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire) begin
        st      <= st_next;
        buf_cnt <= dec_cnt;
      end else if (pop) begin
        buf_cnt <= buf_cnt - 3'd1;
      end
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: input byte and command queue
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= rx_byte;
    end
    if (fire) begin
      for (int i = 0; i < 4; i++) begin
        bufr[i] <= dec_res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < 3; i++) begin
        bufr[i] <= bufr[i+1];
      end
    end
  end

  // Select which coordinate fields a command carries
  assign head     = bufr[0];
  assign use_pos  = (head.cmd == tesc_pkg::CMD_GLYPH) || (head.cmd == tesc_pkg::CMD_COPY) ||
                    (head.cmd == tesc_pkg::CMD_CLEAR);
  assign use_rect = (head.cmd == tesc_pkg::CMD_COPY) || (head.cmd == tesc_pkg::CMD_CLEAR);
  assign use_dest = (head.cmd == tesc_pkg::CMD_COPY);

  // Output register: convert the queue head to pixels
  always_ff @(posedge clk) begin
    if (pop) begin
      command     <= head.cmd;
      left_px     <= use_pos  ? xpix(head.left)   : 11'd0;
      top_px      <= use_pos  ? ypix(head.top)    : 11'd0;
      right_px    <= use_rect ? xpix(head.right)  : 11'd0;
      bottom_px   <= use_rect ? ypix(head.bottom) : 11'd0;
      dest_x_px   <= use_dest ? xpix(head.dest_x) : 11'd0;
      dest_y_px   <= use_dest ? ypix(head.dest_y) : 11'd0;
      glyph_code  <= head.glyph;
      last_of_run <= head.last;
    end
  end

`ifndef SYNTHESIS
  // The newest queued command always closes its byte's run
  a_tail_last: assert property (@(posedge clk) disable iff (rst)
    (buf_cnt != 3'd0) |-> bufr[2'(buf_cnt - 3'd1)].last)
    else $error("queued run does not end with last_of_run");

  // Only the final command of a run is flagged
  a_head_not_last: assert property (@(posedge clk) disable iff (rst)
    (buf_cnt > 3'd1) |-> !bufr[0].last)
    else $error("last_of_run set before the end of a run");

  // The parser never enters an unused phase
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    st.phase <= tesc_pkg::PH_EDIT)
    else $error("parse phase out of range");

  // Bell and boot carry no coordinates
  a_event_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((command == tesc_pkg::CMD_BELL) || (command == tesc_pkg::CMD_BOOT))) |->
    ((left_px == 11'd0) && (top_px == 11'd0) && (right_px == 11'd0) &&
     (bottom_px == 11'd0) && (dest_x_px == 11'd0) && (dest_y_px == 11'd0)))
    else $error("bell or boot with nonzero coordinates");
`endif

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for terminal_escape_decoder.
// Holds a display command tracker that predicts cursor, parser and command output
// per received byte, plus drivers and a monitor. Depends on rtl/tesc_pkg.sv.
`timescale 1ns / 1ps

package tesc_tb_pkg;
  import tesc_pkg::*;

  // Received character codes
  localparam logic [6:0] CH_BEL   = 7'h07;
  localparam logic [6:0] CH_BS    = 7'h08;
  localparam logic [6:0] CH_TAB   = 7'h09;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_VT    = 7'h0B;
  localparam logic [6:0] CH_FF    = 7'h0C;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] CH_DLE   = 7'h10;
  localparam logic [6:0] CH_ESC   = 7'h1B;
  localparam logic [6:0] CH_SPACE = 7'h20;

  // Letters that follow ESC
  localparam logic [6:0] ESC_UP        = 7'h41;
  localparam logic [6:0] ESC_DOWN      = 7'h42;
  localparam logic [6:0] ESC_RIGHT     = 7'h43;
  localparam logic [6:0] ESC_LEFT      = 7'h44;
  localparam logic [6:0] ESC_DEL_LINES = 7'h45;
  localparam logic [6:0] ESC_INS_LINES = 7'h46;
  localparam logic [6:0] ESC_ERASE_EOL = 7'h4B;
  localparam logic [6:0] ESC_GOTO      = 7'h59;
  localparam logic [6:0] ESC_DEL_CHARS = 7'h65;
  localparam logic [6:0] ESC_INS_CHARS = 7'h66;

  // Pending edit kinds
  localparam logic [1:0] EDIT_DEL_LINES = 2'd0;
  localparam logic [1:0] EDIT_DEL_CHARS = 2'd1;
  localparam logic [1:0] EDIT_INS_LINES = 2'd2;
  localparam logic [1:0] EDIT_INS_CHARS = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_LAST_COLUMN = 2'd0;
  localparam logic [1:0] REG_LAST_ROW    = 2'd1;
  localparam logic [1:0] REG_UNUSED_2    = 2'd2;
  localparam logic [1:0] REG_UNUSED_3    = 2'd3;

  localparam logic [6:0] RESET_LAST_COLUMN = 7'd86;
  localparam logic [6:0] RESET_LAST_ROW    = 7'd71;
  localparam int         MAX_PER_BYTE      = 4;

  localparam logic [6:0] CTRL_CODES [8] = '{CH_BEL, CH_DLE, CH_VT, CH_TAB,
                                            CH_BS, CH_LF, CH_CR, CH_FF};
  localparam logic [6:0] MOVE_LETTERS [5] = '{ESC_UP, ESC_DOWN, ESC_RIGHT,
                                              ESC_LEFT, ESC_ERASE_EOL};
  localparam logic [6:0] EDIT_LETTERS [4] = '{ESC_DEL_LINES, ESC_DEL_CHARS,
                                              ESC_INS_LINES, ESC_INS_CHARS};

  // One display command in pixel coordinates, as seen on the output port
  typedef struct packed {
    cmd_t        cmd;
    logic [10:0] left_px;
    logic [10:0] top_px;
    logic [10:0] right_px;
    logic [10:0] bottom_px;
    logic [10:0] dest_x_px;
    logic [10:0] dest_y_px;
    logic [6:0]  glyph_code;
    logic        last_of_run;
  } disp_cmd_t;

  class display_cmd_tracker;
    logic [6:0] last_col;
    logic [6:0] last_row;
    int         cur_col;
    int         cur_row;
    logic [2:0] phase;
    logic [1:0] edit_kind;
    logic [7:0] goto_col;
    disp_cmd_t  byte_cmds [MAX_PER_BYTE];
    int         byte_n;
    disp_cmd_t  pending_cmds [$];
    int         err_count;
    int         seen;

    function new();
      last_col  = RESET_LAST_COLUMN;
      last_row  = RESET_LAST_ROW;
      cur_col   = 0;
      cur_row   = 0;
      phase     = PH_NORMAL;
      edit_kind = EDIT_DEL_LINES;
      goto_col  = 8'd0;
      byte_n    = 0;
      err_count = 0;
      seen      = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [6:0] val);
      case (idx)
        REG_LAST_COLUMN: last_col = val;
        REG_LAST_ROW:    last_row = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    // Cell to pixel, negative cells saturate at zero
    function int xpx(int c);
      if (c < 0) c = 0;
      return (c * CHAR_WIDTH + X_INSET) & 'h7FF;
    endfunction

    function int ypx(int r);
      if (r < 0) r = 0;
      return (r * CHAR_HEIGHT + Y_INSET) & 'h7FF;
    endfunction

    function void emit_cmd(cmd_t c, int l, int t, int r, int b, int dx, int dy,
                           logic [6:0] g);
      disp_cmd_t e;
      if (byte_n >= MAX_PER_BYTE) return;
      e.cmd         = c;
      e.left_px     = 11'(l);
      e.top_px      = 11'(t);
      e.right_px    = 11'(r);
      e.bottom_px   = 11'(b);
      e.dest_x_px   = 11'(dx);
      e.dest_y_px   = 11'(dy);
      e.glyph_code  = g;
      e.last_of_run = 1'b0;
      byte_cmds[byte_n] = e;
      byte_n++;
    endfunction

    function void clear_cells(int x0, int y0, int x1, int y1);
      emit_cmd(CMD_CLEAR, xpx(x0), ypx(y0), xpx(x1), ypx(y1), 0, 0, 7'd0);
    endfunction

    // Hold a point inside 0..last+1 on both axes
    function void clip_cell(inout int x, inout int y);
      if (x < 0) x = 0;
      if (y < 0) y = 0;
      if (x > int'(last_col) + 1) x = int'(last_col) + 1;
      if (y > int'(last_row) + 1) y = int'(last_row) + 1;
    endfunction

    // Copy a region and clear the part it uncovers
    function void copy_region(int ox, int oy, int cx, int cy, int px, int py);
      clip_cell(ox, oy);
      clip_cell(cx, cy);
      clip_cell(px, py);
      if (px == ox && py == oy) return;
      emit_cmd(CMD_COPY, xpx(ox), ypx(oy), xpx(cx), ypx(cy), xpx(px), ypx(py), 7'd0);
      if (px == ox) begin
        if (py < oy) clear_cells(px, cy - oy + py, cx, cy);
        else clear_cells(ox, oy, cx, py);
      end else begin
        if (px < ox) clear_cells(cx - ox + px, py, cx, cy);
        else clear_cells(ox, oy, px, cy);
      end
    endfunction

    // Advance a row, scrolling one line at the bottom
    function void next_line();
      if (cur_row >= int'(last_row)) begin
        copy_region(0, 1, int'(last_col) + 1, int'(last_row) + 1, 0, 0);
        cur_row = int'(last_row);
      end else begin
        cur_row++;
      end
    endfunction

    function void apply_edit(int n);
      int x, y, xe, ye;
      x  = cur_col;
      y  = cur_row;
      xe = int'(last_col) + 1;
      ye = int'(last_row) + 1;
      case (edit_kind)
        EDIT_DEL_LINES: copy_region(0, y + n, xe, ye, 0, y);
        EDIT_DEL_CHARS: copy_region(x + n, y, xe, y + 1, x, y);
        EDIT_INS_LINES: copy_region(0, y, xe, ye - n, 0, y + n);
        default:        copy_region(x, y, xe - n, y + 1, x + n, y);
      endcase
    endfunction

    function void escape_letter(logic [6:0] c);
      case (c)
        ESC_GOTO:      begin phase = PH_YCOL; return; end
        ESC_UP:        cur_row--;
        ESC_DOWN:      next_line();
        ESC_RIGHT:     cur_col++;
        ESC_LEFT:      cur_col--;
        ESC_DEL_LINES: begin edit_kind = EDIT_DEL_LINES; phase = PH_EDIT; return; end
        ESC_DEL_CHARS: begin edit_kind = EDIT_DEL_CHARS; phase = PH_EDIT; return; end
        ESC_INS_LINES: begin edit_kind = EDIT_INS_LINES; phase = PH_EDIT; return; end
        ESC_INS_CHARS: begin edit_kind = EDIT_INS_CHARS; phase = PH_EDIT; return; end
        ESC_ERASE_EOL: clear_cells(cur_col, cur_row, int'(last_col) + 1, cur_row + 1);
        default: ;
      endcase
      phase = PH_NORMAL;
    endfunction

    // Predict the commands of one accepted byte and queue them
    function void note_byte(logic [7:0] b);
      logic [6:0] c;
      bit         done;
      c      = b[6:0];
      done   = 1'b1;
      byte_n = 0;
      case (phase)
        PH_ESC: begin
          escape_letter(c);
          done = (phase == PH_NORMAL);
        end
        PH_YCOL: begin
          goto_col = {1'b0, c} - 8'd32;
          phase    = PH_YROW;
          done     = 1'b0;
        end
        PH_YROW: begin
          cur_col = int'($signed(goto_col));
          cur_row = int'(c) - 32;
          clip_cell(cur_col, cur_row);
          if (cur_col > int'(last_col)) cur_col = int'(last_col);
          if (cur_row > int'(last_row)) cur_row = int'(last_row);
          phase = PH_NORMAL;
        end
        PH_EDIT: begin
          apply_edit(int'(c) - 32);
          phase = PH_NORMAL;
        end
        default: begin
          phase = PH_NORMAL;
          case (c)
            CH_DLE: begin
              emit_cmd(CMD_BOOT, 0, 0, 0, 0, 0, 0, 7'd0);
              done = 1'b0;
            end
            CH_BEL: emit_cmd(CMD_BELL, 0, 0, 0, 0, 0, 0, 7'd0);
            CH_VT:  cur_row--;
            CH_TAB: cur_col = (cur_col | 7) + 1;
            CH_ESC: begin
              phase = PH_ESC;
              done  = 1'b0;
            end
            CH_BS:  cur_col--;
            CH_LF:  next_line();
            CH_CR:  cur_col = 0;
            CH_FF: begin
              clear_cells(0, 0, int'(last_col) + 1, int'(last_row) + 1);
              cur_col = 0;
              cur_row = 0;
            end
            default: begin
              emit_cmd(CMD_GLYPH, xpx(cur_col), ypx(cur_row), 0, 0, 0, 0, c);
              cur_col++;
            end
          endcase
        end
      endcase

      // Wrap at the right edge, then clip the cursor
      if (done) begin
        if (cur_col > int'(last_col)) begin
          next_line();
          cur_col = 0;
        end
        clip_cell(cur_col, cur_row);
        cur_col = cur_col & 'h7F;
        cur_row = cur_row & 'h7F;
      end

      for (int i = 0; i < byte_n; i++) begin
        if (i == byte_n - 1) byte_cmds[i].last_of_run = 1'b1;
        pending_cmds.push_back(byte_cmds[i]);
      end
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH: %s", msg);
      err_count++;
    endtask

    task cmp_field(string fname, int got, int want);
      if (got != want)
        report_mismatch($sformatf("command %0d %s: got %0d, expected %0d",
                                  seen, fname, got, want));
    endtask

    // Compare one accepted command with the oldest prediction
    task check_command(disp_cmd_t got);
      disp_cmd_t want;
      seen++;
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("command %0d arrived with none expected", seen));
        return;
      end
      want = pending_cmds.pop_front();
      cmp_field("command",     got.cmd,         want.cmd);
      cmp_field("left_px",     got.left_px,     want.left_px);
      cmp_field("top_px",      got.top_px,      want.top_px);
      cmp_field("right_px",    got.right_px,    want.right_px);
      cmp_field("bottom_px",   got.bottom_px,   want.bottom_px);
      cmp_field("dest_x_px",   got.dest_x_px,   want.dest_x_px);
      cmp_field("dest_y_px",   got.dest_y_px,   want.dest_y_px);
      cmp_field("glyph_code",  got.glyph_code,  want.glyph_code);
      cmp_field("last_of_run", got.last_of_run, want.last_of_run);
    endtask
  endclass

endpackage

module tb;
  import tesc_pkg::*;
  import tesc_tb_pkg::*;

  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 200000;
  localparam logic [6:0] MIN_DIM = 7'd1;
  localparam logic [6:0] MAX_DIM = 7'd126;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  rx_byte   = 8'd0;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [6:0]  cfg_data  = 7'd0;
  logic        in_stall;
  logic        out_valid;
  logic        cfg_ready;
  logic [2:0]  command;
  logic [10:0] left_px, top_px, right_px, bottom_px, dest_x_px, dest_y_px;
  logic [6:0]  glyph_code;
  logic        last_of_run;

  display_cmd_tracker tracker;
  int sender_pct = 0;
  int stall_pct  = 0;
  int cur_cm     = int'(RESET_LAST_COLUMN);
  int cur_rm     = int'(RESET_LAST_ROW);
  int sent       = 0;
  int cycles     = 0;

  terminal_escape_decoder DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .command     (command),
    .left_px     (left_px),
    .top_px      (top_px),
    .right_px    (right_px),
    .bottom_px   (bottom_px),
    .dest_x_px   (dest_x_px),
    .dest_y_px   (dest_y_px),
    .glyph_code  (glyph_code),
    .last_of_run (last_of_run),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  // End the run if it hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("cycle limit reached");
      $display("TB_ERROR");
      $finish;
    end
  end

  // Stall the command output at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check every accepted command
  always @(posedge clk) begin : monitor
    disp_cmd_t got;
    if (!rst && out_valid && !out_stall) begin
      got.cmd         = cmd_t'(command);
      got.left_px     = left_px;
      got.top_px      = top_px;
      got.right_px    = right_px;
      got.bottom_px   = bottom_px;
      got.dest_x_px   = dest_x_px;
      got.dest_y_px   = dest_y_px;
      got.glyph_code  = glyph_code;
      got.last_of_run = last_of_run;
      tracker.check_command(got);
    end
  end

  // Offer one byte, idling first at random, and hold it until accepted
  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < sender_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_byte(b);
    sent++;
  endtask

  // Drop valid and wait until every predicted command has come out
  task automatic wait_all_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, val);
    if (idx == REG_LAST_COLUMN) cur_cm = int'(val);
    else if (idx == REG_LAST_ROW) cur_rm = int'(val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random top bit over a seven-bit code; the block ignores bit 7
  function automatic logic [7:0] with_top(int v);
    return {1'($urandom_range(1)), 7'(v)};
  endfunction

  // Parameter byte near the screen, sometimes anywhere (negative or huge)
  function automatic logic [7:0] param_byte(int lim);
    if ($urandom_range(5) == 0) return 8'($urandom_range(255));
    return with_top(int'(CH_SPACE) + $urandom_range(lim + 2));
  endfunction

  // Send one mostly well-formed unit: text, control, escape or noise
  task automatic send_random_unit();
    int kind;
    kind = $urandom_range(99);
    if (kind < 38) begin
      send_byte(with_top($urandom_range(32, 126)));
    end else if (kind < 53) begin
      send_byte(with_top(CTRL_CODES[$urandom_range(7)]));
    end else if (kind < 66) begin
      send_byte(with_top(CH_ESC));
      case ($urandom_range(6))
        0: send_byte(with_top(CH_ESC));
        1: send_byte(8'($urandom_range(255)));
        default: send_byte(with_top(MOVE_LETTERS[$urandom_range(4)]));
      endcase
    end else if (kind < 78) begin
      send_byte(with_top(CH_ESC));
      send_byte(with_top(ESC_GOTO));
      send_byte(param_byte(cur_cm));
      send_byte(param_byte(cur_rm));
    end else if (kind < 92) begin
      send_byte(with_top(CH_ESC));
      send_byte(with_top(EDIT_LETTERS[$urandom_range(3)]));
      if ($urandom_range(3) == 0) send_byte(8'($urandom_range(255)));
      else send_byte(with_top(int'(CH_SPACE) + $urandom_range(8)));
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  task automatic run_phase(input logic [6:0] cm, input logic [6:0] rm,
                           input int s_pct, input int r_pct, input int n_bytes);
    int target;
    wait_all_done();
    cfg_write(REG_LAST_COLUMN, cm);
    cfg_write(REG_LAST_ROW, rm);
    sender_pct = s_pct;
    stall_pct  = r_pct;
    target     = sent + n_bytes;
    while (sent < target) begin
      send_random_unit();
      if ($urandom_range(59) == 0) wait_all_done();
    end
  endtask

  logic [7:0] directed [27];

  initial begin
    tracker = new();
    // Field extremes, every control code, bottom-right wrap with scroll,
    // erase to end of line, an edit of each direction, ESC ESC, form feed
    directed = '{8'(CH_BEL), 8'(CH_DLE), 8'h51, 8'hC1, 8'h7F, 8'h00,
                 8'(CH_TAB), 8'(CH_BS), 8'(CH_VT), 8'(CH_CR), 8'(CH_LF),
                 8'(CH_ESC), 8'(ESC_GOTO), 8'(CH_SPACE) + 8'd86, 8'(CH_SPACE) + 8'd71,
                 8'h5A, 8'(CH_ESC), 8'(ESC_ERASE_EOL),
                 8'(CH_ESC), 8'(ESC_DEL_LINES), 8'(CH_SPACE) + 8'd1,
                 8'(CH_ESC), 8'(ESC_INS_CHARS), 8'(CH_SPACE) + 8'd3,
                 8'(CH_ESC), 8'(CH_ESC), 8'(CH_FF)};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_byte(directed[i]);

    run_phase(MAX_DIM, MAX_DIM, 0, 0, 60);
    run_phase(MIN_DIM, MIN_DIM, 51, 0, 55);

    // Writes to unused indexes must leave the screen size alone
    wait_all_done();
    cfg_write(REG_UNUSED_2, 7'($urandom_range(127)));
    cfg_write(REG_UNUSED_3, 7'($urandom_range(127)));

    run_phase(7'($urandom_range(1, 20)), 7'($urandom_range(1, 126)), 0, 51, 80);
    run_phase(MAX_DIM, 7'($urandom_range(1, 12)), 16, 16, 85);

    wait_all_done();
    if (tracker.err_count == 0 && tracker.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/tesc_pkg.sv
rtl/tesc_decode.sv
rtl/terminal_escape_decoder.sv
sim/tb.sv
